// ----- hw/rtl/phlc_pkg.sv -----
package phlc_pkg;

    // Table geometry. TABLE_SLOTS may be any value from 2 to 65536.
    localparam int TABLE_SLOTS = 1024;
    localparam int SLOT_W      = $clog2(TABLE_SLOTS);
    localparam int HALF_SLOTS  = TABLE_SLOTS / 2;
    localparam int CNT_W       = $clog2(HALF_SLOTS + 1);
    localparam int DIV_W       = 17;

    localparam logic [SLOT_W-1:0] SLOT_MAX  = SLOT_W'(TABLE_SLOTS - 1);
    localparam logic [CNT_W-1:0]  CNT_HALF  = CNT_W'(HALF_SLOTS);
    localparam logic [DIV_W-1:0]  SLOT_DIV  = DIV_W'(TABLE_SLOTS);
    // floor(2^32 / TABLE_SLOTS); the quotient estimate it gives is short by at most one.
    localparam logic [63:0]       RECIP_FULL = 64'h1_0000_0000 / 64'(TABLE_SLOTS);
    localparam logic [31:0]       SLOT_RECIP = RECIP_FULL[31:0];

    localparam logic [31:0] KNUTH_MUL = 32'd2654435761;
    localparam logic [31:0] EMPTY_KEY = 32'hFFFF_FFFF;
    localparam logic [15:0] HIT_MAX   = 16'hFFFF;

    // The FNV prime is 2^40 + 0x1B3, so the fold is a shift plus a narrow product.
    localparam logic [63:0] FNV_BASIS    = 64'd1469598103934665603;
    localparam int          FNV_SHIFT    = 40;
    localparam logic [8:0]  FNV_PRIME_LO = 9'h1B3;

    typedef enum logic [1:0] {
        OP_INSERT  = 2'd0,
        OP_BLOCK   = 2'd1,
        OP_EMPTY   = 2'd2,
        OP_RESTART = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STS_DONE     = 2'd0,
        STS_INS_OK   = 2'd1,
        STS_INS_DROP = 2'd2
    } status_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] key;
        logic        last_block;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] prefix_len;
        logic [63:0] checksum;
    } out_item_t;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DECODE,
        S_HASH1,
        S_HASH2,
        S_HASH3,
        S_READ,
        S_PROBE,
        S_ENDBLK,
        S_FOLD,
        S_EMIT
    } ctrl_state_t;

    typedef struct packed {
        logic latch_in;
        logic clr_step;
        logic restart;
        logic clr_req;
        logic set_miss;
        logic hit_inc;
        logic hash1;
        logic hash2;
        logic hash3;
        logic rd_cur;
        logic rd_next;
        logic wr_key;
        logic res_drop;
        logic res_ok;
        logic fold;
        logic load_out;
    } dp_cmd_t;

    typedef struct packed {
        op_t  op;
        logic key_empty;
        logic full;
        logic miss_seen;
        logic last;
        logic clr_last;
        logic probe_hit;
        logic probe_empty;
    } dp_sts_t;

endpackage

// ----- hw/rtl/phlc_dp.sv -----
module phlc_dp
    import phlc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  dp_cmd_t   cmd,
    input  in_item_t  s_data,
    output dp_sts_t   sts,
    output out_item_t m_data
);

    logic [31:0] mem [TABLE_SLOTS];

    logic [1:0]        op_reg;
    logic [31:0]       key_reg;
    logic              last_reg;
    logic [SLOT_W-1:0] idx_reg;
    logic [31:0]       h_reg;
    logic [31:0]       q_reg;
    logic [31:0]       rdata_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [63:0]       sum_reg;
    logic [15:0]       hit_reg;
    logic              miss_reg;
    logic [1:0]        res_status_reg;
    logic [15:0]       res_prefix_reg;
    out_item_t         out_reg;

    logic [SLOT_W-1:0] idx_inc;
    logic [SLOT_W-1:0] rd_addr;
    logic              wr_en;
    logic [31:0]       wr_data;
    logic [63:0]       recip_prod;
    logic [48:0]       qd_prod;
    logic [32:0]       rem_raw;
    logic [32:0]       rem_fix;
    logic [63:0]       fold_x;
    logic [63:0]       sum_next;

    assign idx_inc = (idx_reg == SLOT_MAX) ? '0 : idx_reg + SLOT_W'(1);
    assign rd_addr = cmd.rd_next ? idx_inc : idx_reg;
    assign wr_en   = cmd.clr_step | cmd.wr_key;
    assign wr_data = cmd.clr_step ? EMPTY_KEY : key_reg;

    // Home slot = h mod TABLE_SLOTS via reciprocal estimate and one correction.
    assign recip_prod = {32'd0, h_reg} * {32'd0, SLOT_RECIP};
    assign qd_prod    = {17'd0, q_reg} * {32'd0, SLOT_DIV};
    assign rem_raw    = {1'b0, h_reg} - qd_prod[32:0];
    assign rem_fix    = (rem_raw >= {16'd0, SLOT_DIV}) ? rem_raw - {16'd0, SLOT_DIV} : rem_raw;

    assign fold_x   = sum_reg ^ {48'd0, hit_reg};
    assign sum_next = (fold_x << FNV_SHIFT) + fold_x * {55'd0, FNV_PRIME_LO};

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[idx_reg] <= wr_data;
        end
        if (cmd.rd_cur || cmd.rd_next) begin
            rdata_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.latch_in) begin
            op_reg   <= s_data.op;
            key_reg  <= s_data.key;
            last_reg <= s_data.last_block;
        end
        if (cmd.hash1) begin
            h_reg <= key_reg * KNUTH_MUL;
        end
        if (cmd.hash2) begin
            q_reg <= recip_prod[63:32];
        end
        if (cmd.res_ok || cmd.res_drop) begin
            res_status_reg <= cmd.res_ok ? STS_INS_OK : STS_INS_DROP;
            res_prefix_reg <= '0;
        end else if (cmd.fold) begin
            res_status_reg <= STS_DONE;
            res_prefix_reg <= hit_reg;
        end
        if (cmd.load_out) begin
            out_reg.status     <= res_status_reg;
            out_reg.prefix_len <= res_prefix_reg;
            out_reg.checksum   <= (res_status_reg == STS_DONE) ? sum_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg  <= '0;
            cnt_reg  <= '0;
            sum_reg  <= FNV_BASIS;
            hit_reg  <= '0;
            miss_reg <= 1'b0;
        end else begin
            if (cmd.clr_step) begin
                idx_reg <= idx_inc;
            end else if (cmd.hash3) begin
                idx_reg <= rem_fix[SLOT_W-1:0];
            end else if (cmd.rd_next) begin
                idx_reg <= idx_inc;
            end
            if (cmd.wr_key) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.restart) begin
                sum_reg <= FNV_BASIS;
            end else if (cmd.fold) begin
                sum_reg <= sum_next;
            end
            if (cmd.restart || cmd.clr_req || cmd.fold) begin
                hit_reg  <= '0;
                miss_reg <= 1'b0;
            end else begin
                if (cmd.hit_inc && hit_reg != HIT_MAX) begin
                    hit_reg <= hit_reg + 16'd1;
                end
                if (cmd.set_miss) begin
                    miss_reg <= 1'b1;
                end
            end
        end
    end

    assign sts.op          = op_t'(op_reg);
    assign sts.key_empty   = (key_reg == EMPTY_KEY);
    assign sts.full        = (cnt_reg >= CNT_HALF);
    assign sts.miss_seen   = miss_reg;
    assign sts.last        = last_reg;
    assign sts.clr_last    = (idx_reg == SLOT_MAX);
    assign sts.probe_hit   = (rdata_reg == key_reg);
    assign sts.probe_empty = (rdata_reg == EMPTY_KEY);

    assign m_data = out_reg;

    a_load_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_HALF)
        else $error("stored key count exceeds half the table");

    a_write_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.wr_key |-> (rdata_reg == EMPTY_KEY) && !sts.full)
        else $error("key written over an occupied slot or into a full table");

    a_hit_no_miss: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.hit_inc |-> !miss_reg)
        else $error("hit counted after a miss in the same request");

endmodule

// ----- hw/rtl/phlc_ctrl.sv -----
module phlc_ctrl
    import phlc_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  logic    m_ready,
    input  dp_sts_t sts,
    output dp_cmd_t cmd
);

    ctrl_state_t state_reg, state_next;
    logic        m_valid_reg, m_valid_next;
    logic        out_free;

    assign out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_CLEAR;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            S_CLEAR: begin
                cmd.clr_step = 1'b1;
                if (sts.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.latch_in = 1'b1;
                    state_next   = S_DECODE;
                end
            end
            S_DECODE: begin
                unique case (sts.op)
                    OP_INSERT: begin
                        if (sts.full) begin
                            cmd.res_drop = 1'b1;
                            state_next   = S_EMIT;
                        end else if (sts.key_empty) begin
                            // The reserved key is reported as taken but never stored.
                            cmd.res_ok = 1'b1;
                            state_next = S_EMIT;
                        end else begin
                            state_next = S_HASH1;
                        end
                    end
                    OP_BLOCK: begin
                        if (sts.miss_seen) begin
                            state_next = S_ENDBLK;
                        end else if (sts.key_empty) begin
                            cmd.set_miss = 1'b1;
                            state_next   = S_ENDBLK;
                        end else begin
                            state_next = S_HASH1;
                        end
                    end
                    OP_EMPTY: begin
                        cmd.clr_req = 1'b1;
                        state_next  = S_FOLD;
                    end
                    OP_RESTART: begin
                        cmd.restart = 1'b1;
                        state_next  = S_IDLE;
                    end
                    default: state_next = S_IDLE;
                endcase
            end
            S_HASH1: begin
                cmd.hash1  = 1'b1;
                state_next = S_HASH2;
            end
            S_HASH2: begin
                cmd.hash2  = 1'b1;
                state_next = S_HASH3;
            end
            S_HASH3: begin
                cmd.hash3  = 1'b1;
                state_next = S_READ;
            end
            S_READ: begin
                cmd.rd_cur = 1'b1;
                state_next = S_PROBE;
            end
            S_PROBE: begin
                // Each cycle compares one slot and fetches the next one if needed.
                if (sts.op == OP_INSERT) begin
                    if (sts.probe_empty) begin
                        cmd.wr_key = 1'b1;
                        cmd.res_ok = 1'b1;
                        state_next = S_EMIT;
                    end else begin
                        cmd.rd_next = 1'b1;
                    end
                end else begin
                    if (sts.probe_hit) begin
                        cmd.hit_inc = 1'b1;
                        state_next  = S_ENDBLK;
                    end else if (sts.probe_empty) begin
                        cmd.set_miss = 1'b1;
                        state_next   = S_ENDBLK;
                    end else begin
                        cmd.rd_next = 1'b1;
                    end
                end
            end
            S_ENDBLK: begin
                state_next = sts.last ? S_FOLD : S_IDLE;
            end
            S_FOLD: begin
                cmd.fold   = 1'b1;
                state_next = S_EMIT;
            end
            S_EMIT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    assign m_valid = m_valid_reg;

    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> (!m_valid_reg || m_ready))
        else $error("result register loaded while a transfer is pending");

    a_accept_decode: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> state_reg == S_DECODE)
        else $error("accepted item not decoded in the following cycle");

endmodule

// ----- hw/rtl/prefix_hit_length_checksum.sv -----
// An insert passes decode, the hash steps, a slot read and the probe loop, which probes one
// slot per cycle; a final block also passes the end-of-block and fold steps. An insert that
// stores nothing, an empty request and a final block after a miss skip hashing and probing.
// Throughput: one item at a time, set by the probe loop. A finished result waits in the
// output register while the next item is taken. Reset (aresetn, synchronous, active low) starts
// a clearing pass that writes the empty marker to every slot; no item is taken until it ends.
module prefix_hit_length_checksum
    import phlc_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    phlc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    phlc_dp u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .s_data  (s_data),
        .sts     (sts),
        .m_data  (m_data)
    );

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 100ps
module testbench;
    import phlc_pkg::*;

    localparam int          HALF_PERIOD  = 4;
    localparam int          LIMIT_CYCLES = 4_000_000;
    localparam int          HOLD_CYCLES  = 400;
    localparam logic [63:0] FOLD_MULT    = 64'd1099511628211;

    typedef enum logic [1:0] {
        RX_ALWAYS,
        RX_RANDOM,
        RX_PATTERN,
        RX_SLOW
    } rx_mode_t;

    logic      aclk = 1'b0;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    in_item_t  s_data;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    // Shadow of the cached-key set and the running prefix checksum.
    logic [31:0] slot_copy [TABLE_SLOTS];
    int          keys_held;
    logic [63:0] fold_sum;
    int          hits_run;
    bit          missed;
    out_item_t   due_outcomes[$];
    logic [31:0] key_pool[$];

    int       err_cnt = 0;
    int       items_sent = 0;
    int       burst_left;
    bit       tx_gaps;
    rx_mode_t rx_mode;
    int       hold_req;
    int       hold_ack = 0;
    int       hold_left = 0;
    int       rx_phase = 0;
    int       cyc_count = 0;

    always #HALF_PERIOD aclk = ~aclk;

    prefix_hit_length_checksum u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    function automatic int home_of(logic [31:0] key);
        logic [63:0] prod;
        prod = 64'(key) * 64'(KNUTH_MUL);
        return int'(prod[31:0] % 32'(TABLE_SLOTS));
    endfunction

    function automatic bit is_cached(logic [31:0] key);
        int idx;
        if (key == EMPTY_KEY) return 1'b0;
        idx = home_of(key);
        repeat (TABLE_SLOTS) begin
            if (slot_copy[idx] == key) return 1'b1;
            if (slot_copy[idx] == EMPTY_KEY) return 1'b0;
            idx = (idx + 1) % TABLE_SLOTS;
        end
        return 1'b0;
    endfunction

    task automatic clear_cache_copy();
        foreach (slot_copy[i]) slot_copy[i] = EMPTY_KEY;
        keys_held = 0;
        fold_sum  = FNV_BASIS;
        hits_run  = 0;
        missed    = 1'b0;
    endtask

    task automatic fold_prefix(int prefix);
        out_item_t r;
        fold_sum     = (fold_sum ^ 64'(prefix)) * FOLD_MULT;
        r.status     = STS_DONE;
        r.prefix_len = 16'(prefix);
        r.checksum   = fold_sum;
        due_outcomes.push_back(r);
        hits_run = 0;
        missed   = 1'b0;
    endtask

    task automatic update_hit_table(in_item_t it);
        out_item_t r;
        int        idx;
        case (it.op)
            OP_INSERT: begin
                r.prefix_len = '0;
                r.checksum   = '0;
                if (keys_held >= HALF_SLOTS) begin
                    r.status = STS_INS_DROP;
                end else begin
                    r.status = STS_INS_OK;
                    // The empty marker is acknowledged but never stored.
                    if (it.key != EMPTY_KEY) begin
                        idx = home_of(it.key);
                        while (slot_copy[idx] != EMPTY_KEY) idx = (idx + 1) % TABLE_SLOTS;
                        slot_copy[idx] = it.key;
                        keys_held++;
                    end
                end
                due_outcomes.push_back(r);
            end
            OP_BLOCK: begin
                if (!missed) begin
                    if (is_cached(it.key)) begin
                        if (hits_run < int'(HIT_MAX)) hits_run++;
                    end else begin
                        missed = 1'b1;
                    end
                end
                if (it.last_block) fold_prefix(hits_run);
            end
            OP_EMPTY: fold_prefix(0);
            default: begin
                fold_sum = FNV_BASIS;
                hits_run = 0;
                missed   = 1'b0;
            end
        endcase
    endtask

    task automatic report_mismatch(input string msg);
        if (err_cnt < 50) $display("[%0t] mismatch: %s", $time, msg);
        err_cnt++;
    endtask

    // Sender: bursts of random length separated by random gaps when gaps are enabled.
    task automatic send_item(input in_item_t it);
        int gap;
        if (tx_gaps && burst_left <= 0) begin
            burst_left = $urandom_range(1, 12);
            gap        = $urandom_range(1, 8);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        update_hit_table(it);
        items_sent++;
        if (burst_left > 0) burst_left--;
    endtask

    function automatic in_item_t mk(op_t op, logic [31:0] key, logic last);
        in_item_t it;
        it.op         = op;
        it.key        = key;
        it.last_block = last;
        return it;
    endfunction

    // Searches upward from a random start for a key that lands on the same home slot.
    function automatic logic [31:0] collide_key(logic [31:0] base);
        int          slot;
        logic [31:0] k;
        slot = home_of(base);
        k    = $urandom();
        while (home_of(k) != slot) k++;
        return k;
    endfunction

    function automatic logic [31:0] fresh_key();
        if (key_pool.size() != 0 && $urandom_range(0, 3) == 0)
            return collide_key(key_pool[$urandom_range(0, key_pool.size() - 1)]);
        return $urandom();
    endfunction

    function automatic logic [31:0] pick_key(int hit_pct);
        if (key_pool.size() != 0 && $urandom_range(0, 99) < hit_pct)
            return key_pool[$urandom_range(0, key_pool.size() - 1)];
        return fresh_key();
    endfunction

    task automatic send_insert(input logic [31:0] key);
        send_item(mk(OP_INSERT, key, 1'($urandom_range(0, 1))));
        if (key != EMPTY_KEY) key_pool.push_back(key);
    endtask

    task automatic send_request(int nblk, int hit_pct);
        for (int i = 0; i < nblk; i++)
            send_item(mk(OP_BLOCK, pick_key(hit_pct), i == nblk - 1));
    endtask

    task automatic random_traffic(int n);
        int target;
        int pick;
        target = items_sent + n;
        while (items_sent < target) begin
            pick = $urandom_range(0, 99);
            if (pick < 55)
                send_request($urandom_range(1, 6), 75);
            else if (pick < 75)
                send_insert(fresh_key());
            else if (pick < 80)
                send_insert(pick_key(100));
            else if (pick < 88)
                send_item(mk(OP_EMPTY, $urandom(), 1'($urandom_range(0, 1))));
            else if (pick < 93)
                send_item(mk(OP_RESTART, $urandom(), 1'($urandom_range(0, 1))));
            else
                // A lone block with no last mark leaves the request open.
                send_item(mk(OP_BLOCK, pick_key(50), 1'b0));
        end
    endtask

    task automatic test_directed_basics();
        tx_gaps = 1'b0;
        rx_mode <= RX_ALWAYS;
        send_item(mk(OP_INSERT, 32'h0000_0000, 1'b0));
        send_item(mk(OP_INSERT, 32'hFFFF_FFFE, 1'b1));
        send_item(mk(OP_INSERT, EMPTY_KEY, 1'b0));
        send_item(mk(OP_INSERT, 32'h0000_0000, 1'b0));
        key_pool.push_back(32'h0000_0000);
        key_pool.push_back(32'hFFFF_FFFE);
        send_item(mk(OP_BLOCK, 32'h0000_0000, 1'b0));
        send_item(mk(OP_BLOCK, 32'hFFFF_FFFE, 1'b1));
        send_item(mk(OP_BLOCK, EMPTY_KEY, 1'b1));
        // Blocks after the first miss are not counted.
        send_item(mk(OP_BLOCK, 32'h0000_0000, 1'b0));
        send_item(mk(OP_BLOCK, 32'h0000_0005, 1'b0));
        send_item(mk(OP_BLOCK, 32'h0000_0000, 1'b1));
        send_item(mk(OP_EMPTY, 32'h0000_0000, 1'b0));
        send_item(mk(OP_BLOCK, 32'h0000_0000, 1'b0));
        send_item(mk(OP_EMPTY, 32'hFFFF_FFFF, 1'b1));
        send_item(mk(OP_BLOCK, 32'h0000_0000, 1'b0));
        send_item(mk(OP_RESTART, 32'hA5A5_5A5A, 1'b1));
        send_item(mk(OP_BLOCK, 32'hFFFF_FFFE, 1'b1));
        // An insert inside an open request counts for the blocks that follow it.
        send_item(mk(OP_BLOCK, 32'h0000_0000, 1'b0));
        send_item(mk(OP_INSERT, 32'h0000_0007, 1'b0));
        key_pool.push_back(32'h0000_0007);
        send_item(mk(OP_BLOCK, 32'h0000_0007, 1'b1));
    endtask

    task automatic test_probe_wrap();
        logic [31:0] k;
        k = 32'h0;
        while (home_of(k) != TABLE_SLOTS - 1) k++;
        send_insert(k);
        send_insert(collide_key(k));
        send_insert(collide_key(k));
        send_request(1, 0);
        send_item(mk(OP_BLOCK, key_pool[key_pool.size() - 1], 1'b0));
        send_item(mk(OP_BLOCK, key_pool[key_pool.size() - 2], 1'b1));
    endtask

    task automatic test_random_mix();
        tx_gaps = 1'b1;
        rx_mode <= RX_RANDOM;
        random_traffic(40);
    endtask

    task automatic test_pattern_stall();
        tx_gaps = 1'b0;
        rx_mode <= RX_PATTERN;
        random_traffic(30);
    endtask

    task automatic test_backpressure();
        tx_gaps = 1'b0;
        rx_mode <= RX_ALWAYS;
        hold_req <= hold_req + 1;
        repeat (10) send_insert(fresh_key());
        repeat (5) send_request($urandom_range(1, 4), 80);
        repeat (5) send_item(mk(OP_EMPTY, $urandom(), 1'($urandom_range(0, 1))));
    endtask

    task automatic test_fill_table();
        tx_gaps = 1'b1;
        rx_mode <= RX_SLOW;
        while (keys_held < HALF_SLOTS) begin
            if ($urandom_range(0, 19) < 19)
                send_insert(fresh_key());
            else
                send_request($urandom_range(1, 3), 70);
        end
        send_insert(EMPTY_KEY);
        send_insert(fresh_key());
        send_insert(pick_key(100));
        rx_mode <= RX_RANDOM;
        random_traffic(20);
    endtask

    always @(posedge aclk) begin
        rx_phase <= rx_phase + 1;
        if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_ack != hold_req) begin
            hold_ack  <= hold_req;
            hold_left <= HOLD_CYCLES;
            m_ready   <= 1'b0;
        end else begin
            case (rx_mode)
                RX_ALWAYS:  m_ready <= 1'b1;
                RX_RANDOM:  m_ready <= 1'($urandom_range(0, 1));
                RX_PATTERN: m_ready <= (rx_phase % 7 != 3) && (rx_phase % 29 > 4);
                default:    m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    out_item_t want;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (due_outcomes.size() == 0) begin
                report_mismatch("result transfer with nothing expected");
            end else begin
                want = due_outcomes.pop_front();
                if (m_data.status !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_data.status, want.status));
                if (m_data.prefix_len !== want.prefix_len)
                    report_mismatch($sformatf("prefix_len %0d, expected %0d",
                                              m_data.prefix_len, want.prefix_len));
                if (m_data.checksum !== want.checksum)
                    report_mismatch($sformatf("checksum %h, expected %h",
                                              m_data.checksum, want.checksum));
            end
        end
    end

    always @(posedge aclk) begin
        cyc_count <= cyc_count + 1;
        if (cyc_count == LIMIT_CYCLES) begin
            $display("** prefix_hit_length_checksum: FAILED **");
            $finish;
        end
    end

    initial begin
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_data     = '0;
        rx_mode    = RX_ALWAYS;
        hold_req   = 0;
        tx_gaps    = 1'b0;
        burst_left = 0;
        clear_cache_copy();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed_basics();
        test_probe_wrap();
        test_random_mix();
        test_backpressure();
        test_pattern_stall();
        test_fill_table();

        s_valid <= 1'b0;
        rx_mode <= RX_ALWAYS;
        while (due_outcomes.size() != 0) @(posedge aclk);
        repeat (TABLE_SLOTS + 64) @(posedge aclk);
        if (err_cnt == 0)
            $display("** prefix_hit_length_checksum: PASSED **");
        else
            $display("** prefix_hit_length_checksum: FAILED **");
        $finish;
    end

endmodule

// ----- sim.f -----
hw/rtl/phlc_pkg.sv
hw/rtl/phlc_dp.sv
hw/rtl/phlc_ctrl.sv
hw/rtl/prefix_hit_length_checksum.sv
tb/testbench.sv
